@@ rtl/sbcp_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, register indexes and soft-clip coefficient tables.
package sbcp_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS = 16;

  localparam logic [7:0] REG_BUS_VOLUME  = 8'd0;
  localparam logic [7:0] REG_SOFTCLIP    = 8'd1;
  localparam logic [7:0] REG_GAIN_COMP   = 8'd2;
  localparam logic [7:0] REG_MASTER_DAMP = 8'd3;

  localparam logic [18:0] BUS_VOLUME_RST  = 19'd65536;
  localparam logic [16:0] MASTER_DAMP_RST = 17'd65536;

  typedef struct packed {
    logic [18:0] bus_volume;
    logic [2:0]  softclip_mode;
    logic        gain_comp;
    logic [16:0] master_damp;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic [31:0] pre_mag;
    logic [31:0] post_mag;
    logic        clipped;
  } lane_res_t;

  // alpha, rounded to COEF_FRAC_BITS
  function automatic logic [16:0] alpha_coef(input logic [1:0] k);
    logic [16:0] c;
    case (k)
      2'd0:    c = 17'd95027;
      2'd1:    c = 17'd70124;
      2'd2:    c = 17'd49152;
      default: c = 17'd34734;
    endcase
    return c;
  endfunction

  // 1 / alpha
  function automatic logic [16:0] alpha_inv_coef(input logic [1:0] k);
    logic [16:0] c;
    case (k)
      2'd0:    c = 17'd45197;
      2'd1:    c = 17'd61249;
      2'd2:    c = 17'd87381;
      default: c = 17'd123653;
    endcase
    return c;
  endfunction

  // 2 * alpha / 3, the saturated soft-clip level
  function automatic logic [16:0] alpha23_coef(input logic [1:0] k);
    logic [16:0] c;
    case (k)
      2'd0:    c = 17'd63351;
      2'd1:    c = 17'd46749;
      2'd2:    c = 17'd32768;
      default: c = 17'd23156;
    endcase
    return c;
  endfunction

  // loudness compensation gain
  function automatic logic [17:0] gain_coef(input logic [1:0] k);
    logic [17:0] c;
    case (k)
      2'd0:    c = 18'd77884;
      2'd1:    c = 18'd92453;
      2'd2:    c = 18'd131072;
      default: c = 18'd185479;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/sbcp_if.sv @@
`timescale 1ns / 1ps
// Interfaces: input pair channel, result channel and configuration write channel.
interface sbcp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_in;
  logic signed [31:0] right_in;
  logic               block_last;
  modport source (output valid, left_in, right_in, block_last, input ready);
  modport sink   (input valid, left_in, right_in, block_last, output ready);
endinterface

interface sbcp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_out;
  logic signed [31:0] right_out;
  logic [15:0]        pre_peak_left;
  logic [15:0]        pre_peak_right;
  logic [15:0]        post_peak_left;
  logic [15:0]        post_peak_right;
  logic               clip_seen;
  logic               block_done;
  modport source (output valid, left_out, right_out, pre_peak_left, pre_peak_right,
                  post_peak_left, post_peak_right, clip_seen, block_done, input ready);
  modport sink   (input valid, left_out, right_out, pre_peak_left, pre_peak_right,
                  post_peak_left, post_peak_right, clip_seen, block_done, output ready);
endinterface

interface sbcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sbcp_lane.sv @@
`timescale 1ns / 1ps
// Channel lane: volume, cubic soft clip, hard clip and damping, one step per cycle unless held in the damping step.
module sbcp_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  sample,
  input  sbcp_pkg::cfg_t      cfg,
  input  logic                hold,
  output logic                idle,
  output logic                done,
  output sbcp_pkg::lane_res_t res
);
  import sbcp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_VOL   = 13'b0000000000010,
    S_SAT   = 13'b0000000000100,
    S_XMUL  = 13'b0000000001000,
    S_XDIV  = 13'b0000000010000,
    S_SQ    = 13'b0000000100000,
    S_CUBE  = 13'b0000001000000,
    S_THIRD = 13'b0000010000000,
    S_ALPHA = 13'b0000100000000,
    S_FULL  = 13'b0001000000000,
    S_GAIN  = 13'b0010000000000,
    S_DAMP  = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } lane_step_t;

  lane_step_t         step_r, step_nxt;
  logic signed [31:0] s_r, v_r, h_r;
  logic [31:0]        pre_r, post_r, mag_r;
  logic signed [51:0] prod_r;
  logic               neg_r, sc_en_r, xge_r, clip_r;
  logic [1:0]         k_r;
  logic [48:0]        pa_r;
  logic [15:0]        x_r, sq_r, cube_r, t_r;
  logic [16:0]        p_r;
  logic [32:0]        y_r;

  logic signed [51:0] vol_prod, vol_sh;
  logic signed [31:0] v_sat;
  logic [31:0]        in_mag, v_mag, full, h_mag;
  logic [48:0]        pa;
  logic [32:0]        pnum;
  logic [17:0]        qe;
  logic [18:0]        r1, x_full;
  logic [3:0]         q2;
  logic [15:0]        r2;
  logic [31:0]        sq_p, cube_p;
  logic [32:0]        third_p, ap;
  logic [48:0]        y_p, d_p;
  logic [32:0]        y_c, d_m;
  logic [50:0]        g_p;
  logic [34:0]        g_m;
  logic signed [31:0] sc_val, hc_val, d_val;
  logic               hc_clip;

  assign in_mag = sample[31] ? (~sample + 32'd1) : sample;

  always_comb begin
    vol_prod = $signed({{20{s_r[31]}}, s_r}) * $signed({33'd0, cfg.bus_volume});
    vol_sh   = prod_r >>> FRAC_BITS;
    if (vol_sh > 52'sd2147483647) begin
      v_sat = 32'sh7FFFFFFF;
    end else if (vol_sh < -52'sd2147483648) begin
      v_sat = 32'sh80000000;
    end else begin
      v_sat = vol_sh[31:0];
    end
    v_mag = v_sat[31] ? (~v_sat + 32'd1) : v_sat;

    pa     = {32'd0, alpha_inv_coef(k_r)} * {17'd0, mag_r};
    // divide by 32767 (2^15 if neg): 2^15 - 1 gives a shift-sum quotient
    pnum   = pa_r[48:16];
    qe     = pnum[32:15];
    r1     = {4'd0, pnum[14:0]} + {1'b0, qe};
    q2     = r1[18:15];
    r2     = {1'b0, r1[14:0]} + {12'd0, q2};
    x_full = neg_r ? {1'b0, pa_r[48:31]}
                   : ({1'b0, qe} + {15'd0, q2} + {18'd0, (r2 >= 16'd32767)});

    sq_p    = {16'd0, x_r} * {16'd0, x_r};
    cube_p  = {16'd0, sq_r} * {16'd0, x_r};
    third_p = {17'd0, cube_r} * 33'd43691;
    ap      = {16'd0, alpha_coef(k_r)} * {17'd0, t_r};

    full = neg_r ? 32'h80000000 : 32'h7FFF0000;
    y_p  = {17'd0, full} * {32'd0, p_r};

    y_c = (y_r > 33'h100000000) ? 33'h100000000 : y_r;
    g_p = {18'd0, y_c} * {33'd0, gain_coef(k_r)};
    g_m = cfg.gain_comp ? g_p[50:16] : {2'd0, y_r};

    if (!sc_en_r) begin
      sc_val = v_r;
    end else if (neg_r) begin
      sc_val = (g_m > 35'h080000000) ? 32'sh80000000 : $signed(~g_m[31:0] + 32'd1);
    end else begin
      sc_val = (g_m > 35'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(g_m[31:0]);
    end

    hc_clip = (sc_val > 32'sh7FFF0000);
    hc_val  = hc_clip ? 32'sh7FFF0000 : sc_val;

    h_mag = h_r[31] ? (~h_r + 32'd1) : h_r;
    d_p   = {17'd0, h_mag} * {32'd0, cfg.master_damp};
    d_m   = d_p[48:16];
    if (h_r[31]) begin
      d_val = (d_m > 33'h080000000) ? 32'sh80000000 : $signed(~d_m[31:0] + 32'd1);
    end else begin
      d_val = (d_m > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(d_m[31:0]);
    end
  end

  always_comb begin
    step_nxt = step_r;
    case (step_r)
      S_IDLE:  if (start) step_nxt = S_VOL;
      S_VOL:   step_nxt = S_SAT;
      S_SAT:   step_nxt = S_XMUL;
      S_XMUL:  step_nxt = S_XDIV;
      S_XDIV:  step_nxt = S_SQ;
      S_SQ:    step_nxt = S_CUBE;
      S_CUBE:  step_nxt = S_THIRD;
      S_THIRD: step_nxt = S_ALPHA;
      S_ALPHA: step_nxt = S_FULL;
      S_FULL:  step_nxt = S_GAIN;
      S_GAIN:  step_nxt = S_DAMP;
      S_DAMP:  if (!hold) step_nxt = S_IDLE;
      default: step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      S_IDLE: begin
        s_r   <= sample;
        pre_r <= in_mag;
      end
      S_VOL: prod_r <= vol_prod;
      S_SAT: begin
        v_r     <= v_sat;
        mag_r   <= v_mag;
        post_r  <= v_mag;
        neg_r   <= v_sat[31];
        sc_en_r <= (cfg.softclip_mode inside {[3'd1:3'd4]}) && (v_sat != 32'sd0);
        k_r     <= 2'(cfg.softclip_mode - 3'd1);
      end
      S_XMUL: pa_r <= pa;
      S_XDIV: begin
        xge_r <= (x_full >= 19'd65536);
        x_r   <= x_full[15:0];
      end
      S_SQ:    sq_r   <= sq_p[31:16];
      S_CUBE:  cube_r <= cube_p[31:16];
      S_THIRD: t_r    <= x_r - third_p[32:17];
      S_ALPHA: p_r    <= xge_r ? alpha23_coef(k_r) : ap[32:16];
      S_FULL:  y_r    <= y_p[48:16];
      S_GAIN: begin
        h_r    <= hc_val;
        clip_r <= hc_clip;
      end
      default: ;
    endcase
  end

  assign idle           = (step_r == S_IDLE);
  assign done           = (step_r == S_DAMP) && !hold;
  assign res.sample_out = d_val;
  assign res.pre_mag    = pre_r;
  assign res.post_mag   = post_r;
  assign res.clipped    = clip_r;

endmodule

@@ rtl/sbcp_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: peak and clip tracking over both lanes, block report, output register.
module sbcp_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_in,
  input  logic                done,
  input  sbcp_pkg::lane_res_t res_l,
  input  sbcp_pkg::lane_res_t res_r,
  output logic                hold,
  sbcp_out_if.source          out_ch
);
  import sbcp_pkg::*;

  logic [31:0] pre_l_r, pre_r_r, post_l_r, post_r_r;
  logic        clip_r, last_r, out_valid_r;
  logic [31:0] pre_l_nxt, pre_r_nxt, post_l_nxt, post_r_nxt;
  logic        clip_nxt;
  logic signed [31:0] left_r, right_r;
  logic [15:0] rp_pre_l_r, rp_pre_r_r, rp_post_l_r, rp_post_r_r;
  logic        rp_clip_r, rp_done_r;

  assign pre_l_nxt  = (res_l.pre_mag  > pre_l_r)  ? res_l.pre_mag  : pre_l_r;
  assign pre_r_nxt  = (res_r.pre_mag  > pre_r_r)  ? res_r.pre_mag  : pre_r_r;
  assign post_l_nxt = (res_l.post_mag > post_l_r) ? res_l.post_mag : post_l_r;
  assign post_r_nxt = (res_r.post_mag > post_r_r) ? res_r.post_mag : post_r_r;
  assign clip_nxt   = clip_r | res_l.clipped | res_r.clipped;

  assign hold = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_l_r     <= '0;
      pre_r_r     <= '0;
      post_l_r    <= '0;
      post_r_r    <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (done) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          pre_l_r  <= '0;
          pre_r_r  <= '0;
          post_l_r <= '0;
          post_r_r <= '0;
          clip_r   <= 1'b0;
        end else begin
          pre_l_r  <= pre_l_nxt;
          pre_r_r  <= pre_r_nxt;
          post_l_r <= post_l_nxt;
          post_r_r <= post_r_nxt;
          clip_r   <= clip_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      last_r <= last_in;
    end
    if (done) begin
      left_r      <= $signed(res_l.sample_out);
      right_r     <= $signed(res_r.sample_out);
      // peak magnitudes never exceed 2^31, so the integer part fits 16 bits
      rp_pre_l_r  <= last_r ? pre_l_nxt[31:FRAC_BITS]  : 16'd0;
      rp_pre_r_r  <= last_r ? pre_r_nxt[31:FRAC_BITS]  : 16'd0;
      rp_post_l_r <= last_r ? post_l_nxt[31:FRAC_BITS] : 16'd0;
      rp_post_r_r <= last_r ? post_r_nxt[31:FRAC_BITS] : 16'd0;
      rp_clip_r   <= last_r & clip_nxt;
      rp_done_r   <= last_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.left_out        = left_r;
  assign out_ch.right_out       = right_r;
  assign out_ch.pre_peak_left   = rp_pre_l_r;
  assign out_ch.pre_peak_right  = rp_pre_r_r;
  assign out_ch.post_peak_left  = rp_post_l_r;
  assign out_ch.post_peak_right = rp_post_r_r;
  assign out_ch.clip_seen       = rp_clip_r;
  assign out_ch.block_done      = rp_done_r;

endmodule

@@ rtl/stereo_bus_clip_and_peak_top.sv @@
`timescale 1ns / 1ps
// Top level: configuration registers, two channel lanes and the merge stage.
//
// Stereo bus stage. Each input word is one 16.16 sample pair; the left and right
// samples run through two identical lanes side by side, each applying bus volume
// with 32-bit saturation, the optional cubic soft clip with gain compensation,
// a hard clip to the 16-bit integer range and master damping. One result word
// comes out per input word. The lane sequencer runs one step per cycle but waits
// in its last step while the output register holds a result not yet taken; a
// new word is accepted only once both lanes are back at rest, so a word enters
// the lanes only after the previous word has left both of them. A
// finished result waits in the output register without blocking the next input.
// On a word marked block_last the result carries the integer peak magnitudes
// before and after volume (this word included) and the hard-clip flag, then
// the trackers clear. Write configuration only while the block is idle; the
// configuration channel is always ready and ignores indexes beyond the four
// registers.
module stereo_bus_clip_and_peak_top (
  input  logic         clk,
  input  logic         rst_n,
  sbcp_in_if.sink      in_ch,
  sbcp_out_if.source   out_ch,
  sbcp_cfg_if.sink     cfg_ch
);
  import sbcp_pkg::*;

  cfg_t      cfg_r;
  logic      idle_l, idle_r, done_l, done_r, hold, start;
  lane_res_t res_l, res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_volume    <= BUS_VOLUME_RST;
      cfg_r.softclip_mode <= 3'd0;
      cfg_r.gain_comp     <= 1'b0;
      cfg_r.master_damp   <= MASTER_DAMP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BUS_VOLUME:  cfg_r.bus_volume    <= cfg_ch.data[18:0];
        REG_SOFTCLIP:    cfg_r.softclip_mode <= cfg_ch.data[2:0];
        REG_GAIN_COMP:   cfg_r.gain_comp     <= cfg_ch.data[0];
        REG_MASTER_DAMP: cfg_r.master_damp   <= cfg_ch.data[16:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // take a new word once both lanes are at rest
  assign in_ch.ready = idle_l & idle_r;
  assign start       = in_ch.valid & in_ch.ready;

  sbcp_lane u_lane_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_ch.left_in),
    .cfg    (cfg_r),
    .hold   (hold),
    .idle   (idle_l),
    .done   (done_l),
    .res    (res_l)
  );

  sbcp_lane u_lane_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_ch.right_in),
    .cfg    (cfg_r),
    .hold   (hold),
    .idle   (idle_r),
    .done   (done_r),
    .res    (res_r)
  );

  // lanes run in lockstep, so both finish in the same cycle
  sbcp_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .last_in (in_ch.block_last),
    .done    (done_l & done_r),
    .res_l   (res_l),
    .res_r   (res_r),
    .hold    (hold),
    .out_ch  (out_ch)
  );

endmodule
